@@ rtl/core/oea_pkg.sv @@
// ----------------------------------------------------------------------------
// oea_pkg
// Shared types and constants of the owner extent allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package oea_pkg;

	localparam logic [1:0]  KIND_ASSIGN  = 2'd0;
	localparam logic [1:0]  KIND_RELEASE = 2'd1;
	localparam logic [1:0]  KIND_GROW    = 2'd2;
	localparam logic [1:0]  KIND_NONE    = 2'd3;
	localparam logic [16:0] LOT_SIZE_RST = 17'd100000;
	localparam logic [15:0] LOT_MAX      = 16'hFFFF;
	localparam int          MAX_RES      = 64;

	typedef enum logic [3:0] {
		OP_NONE, OP_CLR, OP_LOAD, OP_HEAD, OP_APOP, OP_AUSE, OP_NPOP, OP_NUSE,
		OP_WRD, OP_WUSE, OP_ERR, OP_FIN, OP_DRD, OP_DLD, OP_DNEXT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad;
		logic is_assign;
		logic rem_zero;
		logic top_zero;
		logic pops_max;
		logic pcnt_zero;
		logic lot_full;
		logic p_null;
		logic n_max;
		logic n_zero;
		logic err;
		logic out_fire;
		logic d_last;
	} status_t;

	typedef struct packed {
		logic [15:0] lot;
		logic [16:0] start;
		logic [16:0] len;
	} ext_t;

	typedef struct packed {
		ext_t ext;
		logic opened;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/core/oea_ctrl.sv @@
// ----------------------------------------------------------------------------
// oea_ctrl
// Sequencer: steps the datapath through clear, assign, walk and drain.
// ----------------------------------------------------------------------------
`default_nettype none
module oea_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire oea_pkg::status_t st,
	output oea_pkg::cmd_t        cmd
);
	import oea_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_HEAD, S_DISP, S_ACHK, S_AUSE, S_ANEW, S_NUSE,
		S_WCHK, S_WUSE, S_FIN, S_DRD, S_DLD, S_DWAIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_CLR:  cmd.op = OP_CLR;
			S_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_HEAD: cmd.op = OP_HEAD;
			S_DISP: cmd.op = OP_NONE;
			S_ACHK: begin
				priority if (st.rem_zero || st.top_zero || st.pops_max) cmd.op = OP_NONE;
				else if (st.pcnt_zero) cmd.op = OP_ERR;
				else cmd.op = OP_APOP;
			end
			S_AUSE: cmd.op = OP_AUSE;
			S_ANEW: begin
				priority if (st.rem_zero) cmd.op = OP_NONE;
				else if (st.lot_full || st.pcnt_zero) cmd.op = OP_ERR;
				else cmd.op = OP_NPOP;
			end
			S_NUSE: cmd.op = OP_NUSE;
			S_WCHK: cmd.op = (st.p_null || st.n_max) ? OP_NONE : OP_WRD;
			S_WUSE: cmd.op = OP_WUSE;
			S_FIN:  cmd.op = OP_FIN;
			S_DRD:  cmd.op = OP_DRD;
			S_DLD:  cmd.op = OP_DLD;
			S_DWAIT: cmd.op = st.out_fire ? OP_DNEXT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			unique case (state_q)
				S_CLR:  if (st.clr_last) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_HEAD;
				S_HEAD: state_q <= S_DISP;
				S_DISP: begin
					priority if (st.bad) state_q <= S_IDLE;
					else if (st.is_assign) state_q <= S_ACHK;
					else state_q <= S_WCHK;
				end
				S_ACHK: begin
					priority if (st.rem_zero || st.top_zero || st.pops_max) state_q <= S_ANEW;
					else if (st.pcnt_zero) state_q <= S_FIN;
					else state_q <= S_AUSE;
				end
				S_AUSE: state_q <= S_ACHK;
				S_ANEW: begin
					priority if (st.rem_zero || st.lot_full || st.pcnt_zero) state_q <= S_FIN;
					else state_q <= S_NUSE;
				end
				S_NUSE: state_q <= S_FIN;
				S_WCHK: state_q <= (st.p_null || st.n_max) ? S_FIN : S_WUSE;
				S_WUSE: state_q <= S_WCHK;
				// drop a step that gave nothing and hit no error
				S_FIN:  state_q <= (st.n_zero && !st.err) ? S_IDLE : S_DRD;
				S_DRD:  state_q <= S_DLD;
				S_DLD:  state_q <= S_DWAIT;
				S_DWAIT: begin
					if (st.out_fire) state_q <= st.d_last ? S_IDLE : S_DRD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/oea_datapath.sv @@
// ----------------------------------------------------------------------------
// oea_datapath
// Stores, counters and result buffer of the extent allocator.
// ----------------------------------------------------------------------------
`default_nettype none
module oea_datapath #(
	parameter int OWNERS = 16384,
	parameter int POOL   = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire oea_pkg::cmd_t    cmd,
	output oea_pkg::status_t      st,
	input  wire logic             cfg_fire,
	input  wire logic [16:0]      lot_size,
	input  wire logic [1:0]       kind,
	input  wire logic [13:0]      owner,
	input  wire logic [16:0]      size,
	input  wire logic [15:0]      crop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            action,
	output logic [15:0]           lot,
	output logic [16:0]           start_res,
	output logic [16:0]           length,
	output logic [13:0]           owner_out,
	output logic [15:0]           crop_out,
	output logic                  opened_lot,
	output logic                  error,
	output logic                  last
);
	import oea_pkg::*;

	localparam int PW = $clog2(POOL);
	localparam int CW = PW + 1;
	localparam int OW = $clog2(OWNERS);
	localparam int RW = $clog2(MAX_RES);
	localparam logic [CW-1:0] POOL_C = CW'(POOL);

	// head and next links: msb set means empty chain
	typedef struct packed {
		ext_t          ext;
		logic [PW:0]   next;
	} piece_t;

	ext_t   fs_mem  [POOL];
	logic [PW-1:0] pl_mem [POOL];
	piece_t pc_mem  [POOL];
	logic [PW:0] hd_mem [OWNERS];
	res_t   rb_mem  [MAX_RES];

	ext_t          fs_rd;
	logic [PW-1:0] pl_rd;
	piece_t        pc_rd;
	logic [PW:0]   hd_rd;
	res_t          rb_rd;

	logic [16:0]   lot_size_q;
	logic [CW-1:0] top_q, pcnt_q, lo_q, fidx_q;
	logic          fresh_q;
	logic [15:0]   lotc_q;
	logic [OW-1:0] clr_q;
	logic [1:0]    kind_q;
	logic [13:0]   owner_q;
	logic [16:0]   rem_q;
	logic [15:0]   crop_q;
	logic [RW-1:0] pops_q, d_q;
	logic [RW:0]   n_q;
	logic          err_q, zero_q, bad_q;
	logic [PW:0]   h_q;

	logic [CW-1:0] top_m1, pcnt_m1;
	logic [31:0]   own_in, own_st;
	logic [OW-1:0] own_in_idx, own_st_idx;
	logic [16:0]   ls, take_a, take_n;
	logic [PW-1:0] node;
	logic          out_fire;

	assign top_m1     = top_q - CW'(1);
	assign pcnt_m1    = pcnt_q - CW'(1);
	assign own_in     = 32'(owner);
	assign own_st     = 32'(owner_q);
	assign own_in_idx = own_in[OW-1:0];
	assign own_st_idx = own_st[OW-1:0];
	assign ls         = (lot_size_q == 17'd0) ? 17'd1 : lot_size_q;
	assign take_a     = (fs_rd.len < rem_q) ? fs_rd.len : rem_q;
	assign take_n     = (rem_q < ls) ? rem_q : ls;
	assign node       = fresh_q ? fidx_q[PW-1:0] : pl_rd;
	assign out_fire   = out_valid && out_ready;

	always_comb begin
		st.clr_last  = (32'(clr_q) == OWNERS - 1);
		st.bad       = bad_q;
		st.is_assign = (kind_q == KIND_ASSIGN);
		st.rem_zero  = (rem_q == 17'd0);
		st.top_zero  = (top_q == '0);
		st.pops_max  = (pops_q == RW'(MAX_RES - 1));
		st.pcnt_zero = (pcnt_q == '0);
		st.lot_full  = (lotc_q == LOT_MAX);
		st.p_null    = h_q[PW];
		st.n_max     = (n_q == (RW+1)'(MAX_RES));
		st.n_zero    = (n_q == '0);
		st.err       = err_q;
		st.out_fire  = out_fire;
		st.d_last    = ({1'b0, d_q} == n_q - (RW+1)'(1));
	end

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lot_size_q <= LOT_SIZE_RST;
			top_q      <= '0;
			pcnt_q     <= POOL_C;
			lo_q       <= POOL_C;
			lotc_q     <= '0;
			clr_q      <= '0;
			out_valid  <= 1'b0;
			kind_q     <= KIND_NONE;
			bad_q      <= 1'b1;
			rem_q      <= '0;
			pops_q     <= '0;
			n_q        <= '0;
			d_q        <= '0;
			err_q      <= 1'b0;
			zero_q     <= 1'b0;
			fresh_q    <= 1'b0;
			h_q        <= '0;
		end else begin
			if (cfg_fire) lot_size_q <= lot_size;
			if (out_fire) out_valid <= 1'b0;
			unique case (cmd.op)
				OP_CLR: clr_q <= clr_q + OW'(1);
				OP_LOAD: begin
					kind_q <= kind;
					rem_q  <= size;
					pops_q <= '0;
					n_q    <= '0;
					d_q    <= '0;
					err_q  <= 1'b0;
					zero_q <= 1'b0;
					bad_q  <= (kind == KIND_NONE) || (own_in >= OWNERS);
				end
				OP_HEAD: h_q <= hd_rd;
				OP_APOP: begin
					top_q   <= top_m1;
					pcnt_q  <= pcnt_m1;
					fresh_q <= (pcnt_m1 < lo_q);
					if (pcnt_m1 < lo_q) lo_q <= pcnt_m1;
				end
				OP_AUSE: begin
					if (fs_rd.len > take_a) top_q <= top_q + CW'(1);
					h_q    <= {1'b0, node};
					n_q    <= n_q + (RW+1)'(1);
					rem_q  <= rem_q - take_a;
					pops_q <= pops_q + RW'(1);
				end
				OP_NPOP: begin
					pcnt_q  <= pcnt_m1;
					lotc_q  <= lotc_q + 16'd1;
					fresh_q <= (pcnt_m1 < lo_q);
					if (pcnt_m1 < lo_q) lo_q <= pcnt_m1;
				end
				OP_NUSE: begin
					h_q <= {1'b0, node};
					n_q <= n_q + (RW+1)'(1);
					if (ls > take_n) begin
						if (top_q < POOL_C) top_q <= top_q + CW'(1);
						else err_q <= 1'b1;
					end
				end
				OP_WUSE: begin
					n_q <= n_q + (RW+1)'(1);
					h_q <= pc_rd.next;
					if (kind_q == KIND_RELEASE) begin
						if (top_q < POOL_C) top_q <= top_q + CW'(1);
						else err_q <= 1'b1;
						if (pcnt_q < POOL_C) pcnt_q <= pcnt_q + CW'(1);
					end
				end
				OP_ERR: err_q <= 1'b1;
				OP_FIN: begin
					// an error with no extent still reports one blank word
					if (err_q && n_q == '0) begin
						n_q    <= (RW+1)'(1);
						zero_q <= 1'b1;
					end
				end
				OP_DLD:   out_valid <= 1'b1;
				OP_DNEXT: d_q <= d_q + RW'(1);
				OP_NONE, OP_WRD, OP_DRD: ;
				default: ;
			endcase
		end
	end

	// payload registers and stores
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_CLR: hd_mem[clr_q] <= {1'b1, PW'(0)};
			OP_LOAD: begin
				owner_q <= owner;
				crop_q  <= crop;
				hd_rd   <= hd_mem[own_in_idx];
			end
			OP_APOP: begin
				fs_rd  <= fs_mem[top_m1[PW-1:0]];
				pl_rd  <= pl_mem[pcnt_m1[PW-1:0]];
				fidx_q <= POOL_C - CW'(1) - pcnt_m1;
			end
			OP_AUSE: begin
				if (fs_rd.len > take_a)
					fs_mem[top_q[PW-1:0]] <= '{fs_rd.lot, fs_rd.start + take_a,
						fs_rd.len - take_a};
				pc_mem[node] <= '{'{fs_rd.lot, fs_rd.start, take_a}, h_q};
				rb_mem[n_q[RW-1:0]] <= '{'{fs_rd.lot, fs_rd.start, take_a}, 1'b0};
			end
			OP_NPOP: begin
				pl_rd  <= pl_mem[pcnt_m1[PW-1:0]];
				fidx_q <= POOL_C - CW'(1) - pcnt_m1;
			end
			OP_NUSE: begin
				if (ls > take_n && top_q < POOL_C)
					fs_mem[top_q[PW-1:0]] <= '{lotc_q, take_n, ls - take_n};
				pc_mem[node] <= '{'{lotc_q, 17'd0, take_n}, h_q};
				rb_mem[n_q[RW-1:0]] <= '{'{lotc_q, 17'd0, take_n}, 1'b1};
			end
			OP_WRD: pc_rd <= pc_mem[h_q[PW-1:0]];
			OP_WUSE: begin
				rb_mem[n_q[RW-1:0]] <= '{pc_rd.ext, 1'b0};
				if (kind_q == KIND_RELEASE) begin
					if (top_q < POOL_C) fs_mem[top_q[PW-1:0]] <= pc_rd.ext;
					if (pcnt_q < POOL_C) pl_mem[pcnt_q[PW-1:0]] <= h_q[PW-1:0];
				end
			end
			// a grow only reads the chain, so keep its head
			OP_FIN: if (kind_q != KIND_GROW) hd_mem[own_st_idx] <= h_q;
			OP_DRD: rb_rd <= rb_mem[d_q];
			OP_DLD: begin
				action     <= zero_q ? KIND_ASSIGN : kind_q;
				lot        <= zero_q ? 16'd0 : rb_rd.ext.lot;
				start_res  <= zero_q ? 17'd0 : rb_rd.ext.start;
				length     <= zero_q ? 17'd0 : rb_rd.ext.len;
				owner_out  <= zero_q ? 14'd0 : owner_q;
				crop_out   <= (!zero_q && kind_q == KIND_GROW) ? crop_q : 16'd0;
				opened_lot <= zero_q ? 1'b0 : rb_rd.opened;
				error      <= err_q;
				last       <= st.d_last;
			end
			OP_NONE, OP_HEAD, OP_ERR, OP_DNEXT: ;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/owner_extent_allocator_core.sv @@
// ----------------------------------------------------------------------------
// owner_extent_allocator_core
// Extent allocator: free-extent stack, per-owner chains, lots opened on demand.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  in       in   in_valid / in_ready     kind, owner, size, crop
//  out      out  out_valid / out_ready   action, lot, start_res, length,
//                                        owner_out, crop_out, opened_lot,
//                                        error, last
//  cfg      in   cfg_valid / cfg_ready   lot_size
//
//  Each extent taken or walked costs one read and one update of the stores;
//  an ignored item ends after dispatch, and the result buffer is drained one
//  word at a time once the item is done.
//  After reset the owner head table is cleared entry by entry before in_ready.
//  One item is worked at a time; out stalls hold the drain.
// ----------------------------------------------------------------------------
`default_nettype none
module owner_extent_allocator_core #(
	parameter int OWNERS = 16384,
	parameter int POOL   = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [13:0] owner,
	input  wire logic [16:0] size,
	input  wire logic [15:0] crop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       action,
	output logic [15:0]      lot,
	output logic [16:0]      start_res,
	output logic [16:0]      length,
	output logic [13:0]      owner_out,
	output logic [15:0]      crop_out,
	output logic             opened_lot,
	output logic             error,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [16:0] lot_size
);
	import oea_pkg::*;

	cmd_t    cmd;
	status_t st;

	assign cfg_ready = 1'b1;

	oea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	oea_datapath #(
		.OWNERS (OWNERS),
		.POOL   (POOL)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_fire   (cfg_valid && cfg_ready),
		.lot_size   (lot_size),
		.kind       (kind),
		.owner      (owner),
		.size       (size),
		.crop       (crop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.action     (action),
		.lot        (lot),
		.start_res  (start_res),
		.length     (length),
		.owner_out  (owner_out),
		.crop_out   (crop_out),
		.opened_lot (opened_lot),
		.error      (error),
		.last       (last)
	);

endmodule
`default_nettype wire

@@ tb/owner_extent_allocator_core_tb.sv @@
// ----------------------------------------------------------------------------
// owner_extent_allocator_core_tb
// Self-checking bench for the extent allocator. A built-in allocator model
// tracks the free stack, the owner chains and the lot counter. It predicts
// every result word and checks it against the output channel, in order. The
// run covers directed corner cases and then random traffic under several
// lot sizes, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module owner_extent_allocator_core_tb;
	import oea_pkg::*;

	localparam int OWNERS   = 16384;
	localparam int POOL     = 4096;
	localparam int SETTLE   = 400;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] lot;
		logic [16:0] start_res;
		logic [16:0] length;
		logic [13:0] owner_out;
		logic [15:0] crop_out;
		logic        opened_lot;
		logic        error;
		logic        last;
	} word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [13:0] owner;
	logic [16:0] size;
	logic [15:0] crop;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  action;
	logic [15:0] lot;
	logic [16:0] start_res;
	logic [16:0] length;
	logic [13:0] owner_out;
	logic [15:0] crop_out;
	logic        opened_lot;
	logic        error;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [16:0] lot_size;

	owner_extent_allocator_core #(.OWNERS(OWNERS), .POOL(POOL)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .owner(owner), .size(size), .crop(crop),
		.out_valid(out_valid), .out_ready(out_ready),
		.action(action), .lot(lot), .start_res(start_res), .length(length),
		.owner_out(owner_out), .crop_out(crop_out), .opened_lot(opened_lot),
		.error(error), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .lot_size(lot_size)
	);

	// allocator model state
	int unsigned m_lot_size;
	int unsigned fs_lot [POOL];
	int unsigned fs_start [POOL];
	int unsigned fs_len [POOL];
	int unsigned fs_top;
	int unsigned pc_lot [POOL];
	int unsigned pc_start [POOL];
	int unsigned pc_len [POOL];
	int unsigned pc_next [POOL];
	int unsigned pc_free [POOL];
	int unsigned pc_free_cnt;
	int unsigned chain_head [OWNERS];
	int unsigned lot_cnt;

	word_t expected_words[$];
	int    send_idle_pct;
	int    recv_stall_pct;
	int    mismatches;
	int    words_seen;
	int    items_sent;
	int    lot_opens;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic bit push_free(int unsigned l, int unsigned s, int unsigned n);
		if (fs_top >= POOL)
			return 1'b0;
		fs_lot[fs_top] = l;
		fs_start[fs_top] = s;
		fs_len[fs_top] = n;
		fs_top++;
		return 1'b1;
	endfunction

	function automatic void add_piece(int unsigned o, int unsigned l, int unsigned s,
			int unsigned n);
		int unsigned idx;
		pc_free_cnt--;
		idx = pc_free[pc_free_cnt] % POOL;
		pc_lot[idx] = l;
		pc_start[idx] = s;
		pc_len[idx] = n;
		pc_next[idx] = chain_head[o];
		chain_head[o] = idx;
	endfunction

	function automatic word_t make_word(logic [1:0] a, int unsigned l, int unsigned s,
			int unsigned n, int unsigned o, int unsigned c, bit op);
		word_t w;
		w = '0;
		w.action = a;
		w.lot = l[15:0];
		w.start_res = s[16:0];
		w.length = n[16:0];
		w.owner_out = o[13:0];
		w.crop_out = c[15:0];
		w.opened_lot = op;
		return w;
	endfunction

	// compute the words one request causes and queue them
	task automatic predict_request(logic [1:0] k, logic [13:0] o, logic [16:0] sz,
			logic [15:0] cp);
		word_t       buffer[$];
		bit          err;
		int unsigned rem, pops, take, ls, p, idx;
		int unsigned e_lot, e_start, e_len;
		err = 1'b0;
		if (k == KIND_NONE)
			return;
		if (k == KIND_ASSIGN) begin
			rem = sz;
			pops = 0;
			while (rem > 0 && fs_top > 0 && pops < MAX_RES - 1) begin
				if (pc_free_cnt == 0) begin
					err = 1'b1;
					break;
				end
				fs_top--;
				idx = fs_top;
				e_lot = fs_lot[idx];
				e_start = fs_start[idx];
				e_len = fs_len[idx];
				take = e_len < rem ? e_len : rem;
				if (e_len > take) begin
					// split: tail goes back on top
					void'(push_free(e_lot, e_start + take, e_len - take));
				end
				add_piece(o, e_lot, e_start, take);
				buffer.push_back(make_word(KIND_ASSIGN, e_lot, e_start, take,
					o, 0, 1'b0));
				rem -= take;
				pops++;
			end
			if (rem > 0 && !err) begin
				if (lot_cnt >= LOT_MAX || pc_free_cnt == 0) begin
					err = 1'b1;
				end else begin
					ls = m_lot_size == 0 ? 1 : m_lot_size;
					take = rem < ls ? rem : ls;
					lot_cnt++;
					lot_opens++;
					add_piece(o, lot_cnt, 0, take);
					buffer.push_back(make_word(KIND_ASSIGN, lot_cnt, 0, take, o, 0, 1'b1));
					if (ls > take && !push_free(lot_cnt, take, ls - take))
						err = 1'b1;
				end
			end
		end else begin
			p = chain_head[o];
			while (p < POOL && buffer.size() < MAX_RES) begin
				if (k == KIND_RELEASE) begin
					buffer.push_back(make_word(KIND_RELEASE, pc_lot[p], pc_start[p],
						pc_len[p], o, 0, 1'b0));
					if (!push_free(pc_lot[p], pc_start[p], pc_len[p]))
						err = 1'b1;
					if (pc_free_cnt < POOL) begin
						pc_free[pc_free_cnt] = p;
						pc_free_cnt++;
					end
				end else begin
					buffer.push_back(make_word(KIND_GROW, pc_lot[p], pc_start[p],
						pc_len[p], o, cp, 1'b0));
				end
				p = pc_next[p];
			end
			if (k == KIND_RELEASE)
				chain_head[o] = p < POOL ? p : POOL;
		end
		if (err && buffer.size() == 0)
			buffer.push_back('0);
		foreach (buffer[i]) begin
			buffer[i].error = err;
			buffer[i].last = (i == buffer.size() - 1);
			expected_words.push_back(buffer[i]);
		end
	endtask

	task automatic send_request(logic [1:0] k, logic [13:0] o, logic [16:0] sz,
			logic [15:0] cp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		owner <= o;
		size <= sz;
		crop <= cp;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		predict_request(k, o, sz, cp);
	endtask

	// drop valid, let every expected word arrive, then let the block settle
	task automatic drain_all();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_lot_size(int unsigned v);
		drain_all();
		cfg_valid <= 1'b1;
		lot_size <= v[16:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		m_lot_size = v & 32'h1FFFF;
		@(posedge clk);
	endtask

	// result channel: random stalls, in-order compare
	always @(posedge clk) begin
		word_t got, want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{action, lot, start_res, length, owner_out, crop_out,
					opened_lot, error, last};
				words_seen++;
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %p", got);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word mismatch: expected %p, got %p", want, got);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic test_reset_lot_size();
		send_request(KIND_ASSIGN, 14'd0, 17'd1, 16'd0);
		send_request(KIND_ASSIGN, 14'd0, 17'd100000, 16'd0);
		send_request(KIND_ASSIGN, 14'd3, 17'd100000, 16'hFFFF);
		send_request(KIND_GROW, 14'd0, 17'h1FFFF, 16'hFFFF);
		send_request(KIND_GROW, 14'd0, 17'd0, 16'd0);
	endtask

	task automatic test_ignored_requests();
		send_request(KIND_ASSIGN, 14'd1, 17'd0, 16'd0);
		send_request(KIND_NONE, 14'h3FFF, 17'h1FFFF, 16'hFFFF);
		send_request(KIND_RELEASE, 14'h3FFF, 17'd5, 16'd0);
		send_request(KIND_GROW, 14'h3FFF, 17'd5, 16'h1234);
		drain_all();
	endtask

	task automatic test_release_and_reuse();
		send_request(KIND_RELEASE, 14'd0, 17'd0, 16'd0);
		send_request(KIND_ASSIGN, 14'h3FFF, 17'd2, 16'd0);
		send_request(KIND_ASSIGN, 14'h3FFF, 17'd99998, 16'd0);
		send_request(KIND_RELEASE, 14'd3, 17'd0, 16'd0);
	endtask

	task automatic test_result_limits();
		int i;
		write_lot_size(1);
		for (i = 0; i < 3; i++)
			send_request(KIND_ASSIGN, 14'd5, 17'd30, 16'd0);
		send_request(KIND_RELEASE, 14'd5, 17'd0, 16'd0);
		// stack now holds many single cells: long pops, then a new lot
		send_request(KIND_ASSIGN, 14'd6, 17'd70, 16'd0);
		send_request(KIND_ASSIGN, 14'd6, 17'd20, 16'd0);
		send_request(KIND_GROW, 14'd6, 17'd0, 16'hA5A5);
		send_request(KIND_RELEASE, 14'd6, 17'd0, 16'd0);
		send_request(KIND_RELEASE, 14'd6, 17'd0, 16'd0);
		write_lot_size(0);
		send_request(KIND_ASSIGN, 14'd7, 17'd3, 16'd0);
		drain_all();
	endtask

	task automatic test_random_traffic(int unsigned ls, int idle, int stall, int count);
		int          i, r;
		logic [1:0]  k;
		logic [13:0] o;
		logic [16:0] sz;
		write_lot_size(ls);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (i = 0; i < count; i++) begin
			r = $urandom_range(99);
			k = r < 50 ? KIND_ASSIGN : r < 72 ? KIND_RELEASE : r < 95 ? KIND_GROW : KIND_NONE;
			o = $urandom_range(99) < 8 ? 14'($urandom) : 14'($urandom_range(7));
			r = $urandom_range(99);
			if (r < 4)
				sz = 17'd0;
			else if (r < 14)
				sz = 17'($urandom_range(100000, 1));
			else
				sz = 17'($urandom_range(200, 1));
			send_request(k, o, sz, 16'($urandom));
			if (i == count / 2)
				drain_all();
		end
		drain_all();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		owner = '0;
		size = '0;
		crop = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		lot_size = '0;
		m_lot_size = LOT_SIZE_RST;
		fs_top = 0;
		for (int i = 0; i < POOL; i++)
			pc_free[i] = POOL - 1 - i;
		pc_free_cnt = POOL;
		for (int i = 0; i < OWNERS; i++)
			chain_head[i] = POOL;
		lot_cnt = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		words_seen = 0;
		items_sent = 0;
		lot_opens = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_lot_size();
		test_ignored_requests();
		test_release_and_reuse();
		test_result_limits();
		test_random_traffic(1000, 0, 0, 100);
		test_random_traffic(37, 59, 0, 100);
		test_random_traffic($urandom_range(100000, 1), 0, 59, 100);
		test_random_traffic(100000, 27, 27, 100);
		test_random_traffic(1, 0, 0, 20);

		$display("requests sent: %0d, result words checked: %0d, lots opened: %0d",
			items_sent, words_seen, lot_opens);
		$display("lot sizes from 0 to 100000, sender gaps and receiver stalls mixed");
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("mismatches: %0d, words still expected: %0d",
				mismatches, expected_words.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire
